// ===== rtl/core/ptw_pkg.sv =====
// Shared types and constants for the four-level page table walker.
// Holds the channel payload structs, operation codes and the entry index helper.
// No dependencies.
package ptw_pkg;

  localparam int OFFSET_BITS  = 12;
  localparam int INDEX_BITS   = 9;
  localparam int FRAME_LSB    = 12;
  localparam int FRAME_MSB    = 51;
  localparam int ENTRY_SHIFT  = 3;
  localparam int PRESENT_BIT  = 0;
  localparam int LOGICAL_BITS = 48;
  localparam int PA_BITS      = 52;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic       OP_LOAD      = 1'b0;
  localparam logic       OP_TRANSLATE = 1'b1;
  localparam logic [1:0] FIRST_LEVEL  = 2'd0;
  localparam logic [1:0] LAST_LEVEL   = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [63:0] address;
    logic [63:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic               fault;
    logic [PA_BITS-1:0] phys_addr;
  } out_item_t;

  // Head of the front queue as seen by the back end.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } ptw_req_t;

  // Table index for one level: bits 47..39, 38..30, 29..21, 20..12.
  function automatic logic [INDEX_BITS-1:0] level_index(
    input logic [LOGICAL_BITS-1:0] logical,
    input logic [1:0]              level
  );
    logic [INDEX_BITS-1:0] idx;
    unique case (level)
      2'd0:    idx = logical[47:39];
      2'd1:    idx = logical[38:30];
      2'd2:    idx = logical[29:21];
      default: idx = logical[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/core/ptw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptw_ram #(
  parameter int WIDTH     = 64,
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [2**ADDR_BITS];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ptw_front.sv =====
// Front end of the walker: accepts input transactions, drops unusable loads
// and queues the rest for the back end. Depends on ptw_pkg.
module ptw_front
  import ptw_pkg::*;
#(
  parameter int WORD_ADDR_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     enable,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output ptw_req_t head,
  input  logic     pop
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

  in_item_t              q_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  load_ok;
  logic                  keep;
  logic                  push;
  logic                  do_pop;

  // A load is usable when aligned and inside the memory.
  assign load_ok  = (in_data.address[ENTRY_SHIFT-1:0] == '0) &&
                    ((in_data.address >> (WORD_ADDR_BITS + ENTRY_SHIFT)) == 64'd0);
  assign keep     = (in_data.operation == OP_TRANSLATE) || load_ok;
  assign in_ready = enable && (cnt_r != FULL_CNT);
  assign push     = in_valid && in_ready && keep;
  assign do_pop   = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

// ===== rtl/core/ptw_back.sv =====
// Back end of the walker: clears the word memory after reset, performs loads
// and four-level walks, and holds results in an output register.
// Depends on ptw_pkg and ptw_ram.
module ptw_back
  import ptw_pkg::*;
#(
  parameter int WORD_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] root,
  input  ptw_req_t    head,
  output logic        pop,
  output logic        ready_for_items,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  localparam int WIDX_BITS = (FRAME_MSB - FRAME_LSB + 1) + INDEX_BITS;

  state_t                      state_r, state_nxt;
  logic [WORD_ADDR_BITS-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [1:0]                  level_r, level_nxt;
  logic [LOGICAL_BITS-1:0]     logical_r, logical_nxt;
  logic                        res_fault_r, res_fault_nxt;
  logic [PA_BITS-1:0]          res_pa_r, res_pa_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_item_t                   out_item_r, out_item_nxt;

  logic                        ram_we;
  logic [WORD_ADDR_BITS-1:0]   ram_waddr;
  logic [63:0]                 ram_wdata;
  logic                        ram_re;
  logic [WORD_ADDR_BITS-1:0]   ram_raddr;
  logic [63:0]                 ram_rdata;

  logic [63:0]                 ea0;
  logic                        ea0_ok;
  logic [INDEX_BITS-1:0]       idx_next;
  logic [WIDX_BITS-1:0]        next_widx;
  logic                        next_ok;
  logic                        out_free;

  ptw_ram #(
    .WIDTH    (64),
    .ADDR_BITS(WORD_ADDR_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // First read: root plus eight times the top index, wrapping at 64 bits.
  assign ea0    = root + {52'd0, level_index(head.item.address[LOGICAL_BITS-1:0], FIRST_LEVEL),
                          3'd0};
  assign ea0_ok = (ea0[ENTRY_SHIFT-1:0] == '0) &&
                  ((ea0 >> (WORD_ADDR_BITS + ENTRY_SHIFT)) == 64'd0);

  // Later reads: frame bases are page aligned, so no add is needed.
  assign idx_next  = level_index(logical_r, level_r + 2'd1);
  assign next_widx = {ram_rdata[FRAME_MSB:FRAME_LSB], idx_next};
  assign next_ok   = ((next_widx >> WORD_ADDR_BITS) == '0);

  assign out_free        = !out_valid_r || out_ready;
  assign ready_for_items = (state_r != S_CLEAR);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    level_nxt     = level_r;
    logical_nxt   = logical_r;
    res_fault_nxt = res_fault_r;
    res_pa_nxt    = res_pa_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = clr_cnt_r;
    ram_wdata     = 64'd0;
    ram_re        = 1'b0;
    ram_raddr     = ea0[WORD_ADDR_BITS+ENTRY_SHIFT-1:ENTRY_SHIFT];

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.operation == OP_LOAD) begin
            ram_we    = 1'b1;
            ram_waddr = head.item.address[WORD_ADDR_BITS+ENTRY_SHIFT-1:ENTRY_SHIFT];
            ram_wdata = head.item.entry_value;
          end else begin
            logical_nxt = head.item.address[LOGICAL_BITS-1:0];
            level_nxt   = FIRST_LEVEL;
            if (ea0_ok) begin
              ram_re    = 1'b1;
              state_nxt = S_WALK;
            end else begin
              res_fault_nxt = 1'b1;
              res_pa_nxt    = '0;
              state_nxt     = S_RESP;
            end
          end
        end
      end
      S_WALK: begin
        ram_raddr = next_widx[WORD_ADDR_BITS-1:0];
        if (!ram_rdata[PRESENT_BIT]) begin
          res_fault_nxt = 1'b1;
          res_pa_nxt    = '0;
          state_nxt     = S_RESP;
        end else if (level_r == LAST_LEVEL) begin
          res_fault_nxt = 1'b0;
          res_pa_nxt    = {ram_rdata[FRAME_MSB:FRAME_LSB], logical_r[OFFSET_BITS-1:0]};
          state_nxt     = S_RESP;
        end else if (next_ok) begin
          ram_re    = 1'b1;
          level_nxt = level_r + 2'd1;
        end else begin
          res_fault_nxt = 1'b1;
          res_pa_nxt    = '0;
          state_nxt     = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.fault     = res_fault_r;
          out_item_nxt.phys_addr = res_pa_r;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      level_r     <= FIRST_LEVEL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    logical_r   <= logical_nxt;
    res_fault_r <= res_fault_nxt;
    res_pa_r    <= res_pa_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !pop)
    else $error("queue popped during memory clear");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> !ram_we)
    else $error("memory written during a walk");

  a_walk_ends_at_last_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && level_r == LAST_LEVEL) |=> (state_r == S_RESP))
    else $error("walk went past the last level");

  a_fault_has_zero_address: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.fault) |-> (out_item_r.phys_addr == '0))
    else $error("faulting result carries an address");

endmodule

// ===== rtl/core/four_level_page_table_walk.sv =====
// Four-level page table walker: top level with the root register.
// Instantiates ptw_front and ptw_back; depends on ptw_pkg.
//
// Usage:
//   cfg channel  - cfg_valid/cfg_ready/cfg_data write the root table byte
//                  address. Always ready; write only while the block is idle.
//   in channel   - in_valid/in_ready/in_data. operation load stores
//                  entry_value at a byte address (no result); unaligned or
//                  out-of-range loads are dropped. operation translate walks
//                  four table levels for address[47:0].
//   out channel  - out_valid/out_ready/out_data, one transaction per translate:
//                  fault, or the 52-bit physical address.
// A translate goes from the queue head to the output register through an issue
//   step (IDLE), one memory read per level (WALK) and a result step (RESP). A
//   load is written to memory in the same cycle it is popped. The front queue holds two items.
// Throughput: one translate at a time; loads retire one per cycle while the back end is idle.
// Reset: the word memory is zeroed by a sweep over all 2^WORD_ADDR_BITS words,
//   one word per cycle; in_ready stays low until it ends. cfg writes are taken.
// Stall: a held result stalls the next translate in RESP, and loads behind it wait
//   too; loads ahead of it still proceed and the queue keeps accepting until full.
module four_level_page_table_walk
  import ptw_pkg::*;
#(
  parameter int WORD_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic [63:0] root_r;
  ptw_req_t    head;
  logic        pop;
  logic        back_ready;

  // Root register: always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      root_r <= cfg_data;
    end
  end

  // Front: accept, drop unusable loads, queue.
  ptw_front #(
    .WORD_ADDR_BITS(WORD_ADDR_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .enable  (back_ready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .head    (head),
    .pop     (pop)
  );

  // Back: memory clear, loads, walks, output register.
  ptw_back #(
    .WORD_ADDR_BITS(WORD_ADDR_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .root           (root_r),
    .head           (head),
    .pop            (pop),
    .ready_for_items(back_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule
